/* rtl/pfsb_pkg.sv */
// ----------------------------------------------------------------------------
// pfsb_pkg
// Shared constants, sprite ROM contents and ROM lookup for the sprite blitter.
// ----------------------------------------------------------------------------
package pfsb_pkg;

  localparam logic [7:0] ROM_COLUMNS = 8'd84;
  localparam logic [4:0] ROM_ROWS    = 5'd16;
  localparam int         ROM_DEPTH   = 168;

  localparam logic [2:0] MAX_WIDTH  = 3'd7;
  localparam logic [2:0] MAX_HEIGHT = 3'd4;

  localparam logic [7:0] CMD_PAGE   = 8'h40;
  localparam logic [7:0] CMD_COLUMN = 8'h80;

  localparam logic [7:0] SPRITE_ROM [0:ROM_DEPTH-1] = '{
    8'h00, 8'h6e, 8'h8a, 8'hea, 8'h8a, 8'hee, 8'h00, 8'h64, 8'h84, 8'he4, 8'h84, 8'h84,
    8'h00, 8'h6e, 8'h82, 8'hee, 8'ha8, 8'hee, 8'h00, 8'hae, 8'ha2, 8'hee, 8'ha2, 8'hae,
    8'h00, 8'hea, 8'h4a, 8'h4e, 8'h42, 8'he2, 8'h00, 8'h2e, 8'h28, 8'h2e, 8'ha2, 8'h6e,
    8'h00, 8'hae, 8'ha8, 8'hce, 8'haa, 8'hae, 8'h00, 8'h8e, 8'h82, 8'h82, 8'h82, 8'he2,
    8'h00, 8'hae, 8'hea, 8'hee, 8'haa, 8'hae, 8'h00, 8'hae, 8'hea, 8'hee, 8'he2, 8'hae,
    8'h00, 8'h44, 8'haa, 8'hae, 8'haa, 8'h4a, 8'h00, 8'hcc, 8'haa, 8'hec, 8'h8a, 8'h8e,
    8'h00, 8'h46, 8'ha8, 8'ha8, 8'he8, 8'h6e, 8'h00, 8'hcc, 8'haa, 8'hea, 8'hca, 8'hae,
    8'h00, 8'h46, 8'h48, 8'h44, 8'h02, 8'h4e, 8'h00, 8'hee, 8'h24, 8'h64, 8'h04, 8'h44,
    8'h00, 8'haa, 8'haa, 8'h0a, 8'haa, 8'h46, 8'h00, 8'haa, 8'h4a, 8'hea, 8'h44, 8'ha4,
    8'h00, 8'h0a, 8'h0a, 8'h0e, 8'h0e, 8'h4a, 8'h00, 8'h4a, 8'h4a, 8'h04, 8'h0a, 8'h0a,
    8'h00, 8'hea, 8'hea, 8'he4, 8'he4, 8'he4, 8'h00, 8'h0e, 8'h02, 8'h04, 8'h08, 8'h0e,
    8'h00, 8'h06, 8'h06, 8'h1e, 8'h1e, 8'h18, 8'h18, 8'h00, 8'h18, 8'h18, 8'h1e, 8'h1e,
    8'h06, 8'h06, 8'hc0, 8'hc6, 8'hf6, 8'hf6, 8'hc6, 8'hc6, 8'h06, 8'hc6, 8'hc6, 8'hc0,
    8'hc6, 8'hf6, 8'hf6, 8'h06, 8'h1e, 8'h1e, 8'h00, 8'h1e, 8'h1e, 8'h1e, 8'h1e, 8'h00
  };

  // blank outside the ROM
  function automatic logic rom_bit(input logic [7:0] col, input logic [4:0] row);
    logic [7:0] addr;
    logic [7:0] data;
    addr = row[3] ? (col + ROM_COLUMNS) : col;
    data = SPRITE_ROM[addr];
    if (col >= ROM_COLUMNS || row >= ROM_ROWS) begin
      return 1'b0;
    end
    return data[row[2:0]];
  endfunction

endpackage

/* rtl/pfsb_req_if.sv */
// ----------------------------------------------------------------------------
// pfsb_req_if
// Blit request channel: one word per request.
// ----------------------------------------------------------------------------
interface pfsb_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [6:0] map_x;
  logic [3:0] map_y;
  logic [2:0] width;
  logic [2:0] height;

  modport source (
    output valid, operation, pos_x, pos_y, map_x, map_y, width, height,
    input  ready
  );
  modport sink (
    input  valid, operation, pos_x, pos_y, map_x, map_y, width, height,
    output ready
  );
endinterface

/* rtl/pfsb_out_if.sv */
// ----------------------------------------------------------------------------
// pfsb_out_if
// Display byte channel: command or data word toward the LCD controller.
// ----------------------------------------------------------------------------
interface pfsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (
    output valid, out_byte, is_data, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, is_data, last,
    output ready
  );
endinterface

/* rtl/pfsb_ram.sv */
// ----------------------------------------------------------------------------
// pfsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/page_framebuffer_sprite_blit.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_sprite_blit
// Page-mode monochrome LCD sprite blitter with its own frame store.
//
// The blit channel takes one request word: draw or erase, screen position,
// source origin in the built-in 84x16 sprite ROM, width and height. The lcd
// channel returns the byte stream for the display controller: per sprite row
// a page command, per column a column command, and for every on-screen pixel
// whose source bit is set the updated frame-store byte as data. last marks
// the final word of a request.
// A small sequencer walks rows and columns; the frame-store byte for a
// data word is read while its column command is emitted, then updated and
// written back as the data word leaves. The sequencer stalls while the
// receiver holds ready low. blit.ready is high only between requests. A
// finished word waits in the output register while the sequencer stalls
// behind it; nothing is dropped.
// After reset the frame store is cleared, one byte per cycle, through all
// SCREEN_PAGES*SCREEN_COLUMNS bytes; no request is taken during that pass.
// ----------------------------------------------------------------------------
module page_framebuffer_sprite_blit
  import pfsb_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 84,
  parameter int SCREEN_PAGES   = 6
) (
  input  logic       clk,
  input  logic       rst,
  pfsb_req_if.sink   blit,
  pfsb_out_if.source lcd
);

  localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0]    COL_LIMIT = 9'(SCREEN_COLUMNS);
  localparam logic [8:0]    ROW_LIMIT = 9'(8 * SCREEN_PAGES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PAGE  = 3'd2;
  localparam logic [2:0] S_COL   = 3'd3;
  localparam logic [2:0] S_DATA  = 3'd4;

  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_addr;
  logic          op;
  logic [7:0]    px, py;
  logic [6:0]    mx;
  logic [3:0]    my;
  logic [2:0]    w, h;
  logic [1:0]    r, r_next;
  logic [2:0]    c, c_next;
  logic [AW-1:0] idx;

  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_is_data;
  logic          out_last;

  logic          out_free;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_is_data;
  logic          emit_last;

  logic [7:0]    sx, sy;
  logic          row_end, col_end;
  logic          hit;
  logic [AW-1:0] idx_c;
  logic [7:0]    mask;
  logic [7:0]    new_byte;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign out_free = !out_valid || lcd.ready;
  assign sx       = px + {5'b0, c};
  assign sy       = py + {6'b0, r};
  assign row_end  = ({1'b0, r} == (h - 3'd1));
  assign col_end  = (c == (w - 3'd1));
  assign hit      = rom_bit({1'b0, mx} + {5'b0, c}, {1'b0, my} + {3'b0, r})
                    && ({1'b0, sx} < COL_LIMIT) && ({1'b0, sy} < ROW_LIMIT);
  assign idx_c    = AW'(sy[7:3]) * AW'(SCREEN_COLUMNS) + AW'(sx);
  assign mask     = 8'd1 << sy[2:0];
  assign new_byte = op ? (ram_rdata | mask) : (ram_rdata & ~mask);

  assign ram_raddr = (state == S_COL) ? idx_c : idx;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = new_byte;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'd0;
    end else if (state == S_DATA && out_free) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next   = state;
    r_next       = r;
    c_next       = c;
    emit         = 1'b0;
    emit_byte    = CMD_PAGE | {3'b0, sy[7:3]};
    emit_is_data = 1'b0;
    emit_last    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        r_next = 2'd0;
        c_next = 3'd0;
        if (blit.valid && blit.height != 3'd0) begin
          state_next = S_PAGE;
        end
      end
      S_PAGE: begin
        emit_byte = CMD_PAGE | {3'b0, sy[7:3]};
        emit_last = row_end && (w == 3'd0);
        if (out_free) begin
          emit   = 1'b1;
          c_next = 3'd0;
          if (w != 3'd0) begin
            state_next = S_COL;
          end else if (row_end) begin
            state_next = S_IDLE;
          end else begin
            r_next = r + 2'd1;
          end
        end
      end
      S_COL: begin
        emit_byte = CMD_COLUMN | sx;
        emit_last = row_end && col_end && !hit;
        if (out_free) begin
          emit = 1'b1;
          if (hit) begin
            state_next = S_DATA;
          end else if (!col_end) begin
            c_next = c + 3'd1;
          end else if (row_end) begin
            state_next = S_IDLE;
          end else begin
            r_next     = r + 2'd1;
            state_next = S_PAGE;
          end
        end
      end
      S_DATA: begin
        emit_byte    = new_byte;
        emit_is_data = 1'b1;
        emit_last    = row_end && col_end;
        if (out_free) begin
          emit = 1'b1;
          if (!col_end) begin
            c_next     = c + 3'd1;
            state_next = S_COL;
          end else if (row_end) begin
            state_next = S_IDLE;
          end else begin
            r_next     = r + 2'd1;
            state_next = S_PAGE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign blit.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (lcd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r <= r_next;
    c <= c_next;
    if (state == S_COL) begin
      idx <= idx_c;
    end
    if (blit.valid && blit.ready) begin
      op <= blit.operation;
      px <= blit.pos_x;
      py <= blit.pos_y;
      mx <= blit.map_x;
      my <= blit.map_y;
      w  <= (blit.width > MAX_WIDTH) ? MAX_WIDTH : blit.width;
      h  <= (blit.height > MAX_HEIGHT) ? MAX_HEIGHT : blit.height;
    end
    if (emit) begin
      out_byte    <= emit_byte;
      out_is_data <= emit_is_data;
      out_last    <= emit_last;
    end
  end

  assign lcd.valid    = out_valid;
  assign lcd.out_byte = out_byte;
  assign lcd.is_data  = out_is_data;
  assign lcd.last     = out_last;

  pfsb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the sprite blitter's byte stream against a predictor in the bench.
// The bench keeps its own copy of the frame store and expands each accepted
// request into page, column and data words. A directed table runs first,
// then random sprite moves (erase then redraw) mixed with noise requests.
// Random gaps on the request side and random stalls on the lcd side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfsb_pkg::*;

  localparam int SCREEN_COLUMNS = 84;
  localparam int SCREEN_PAGES   = 6;
  localparam int RANDOM_ITEMS   = 230;
  localparam int DRAIN_CYCLES   = 100;
  localparam int CYCLE_LIMIT    = 2_000_000;

  localparam logic OP_ERASE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [6:0] map_x;
    logic [3:0] map_y;
    logic [2:0] width;
    logic [2:0] height;
  } blit_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } lcd_word_t;

  typedef lcd_word_t [0:2] word_set_t;

  typedef struct packed {
    blit_req_t  req;
    logic       typed;
    logic [1:0] n_typed;
    word_set_t  words;
  } directed_row_t;

  localparam word_set_t NO_WORDS = '0;
  localparam int N_DIRECTED = 24;

  // typed rows carry the full expected stream; the rest go through the predictor
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_DRAW,  8'd0,   8'd0,   7'd0,   4'd0,  3'd1, 3'd1}, 1'b1, 2'd2,
      '{{CMD_PAGE, 1'b0, 1'b0}, {CMD_COLUMN, 1'b0, 1'b1}, '0}},
    '{'{OP_DRAW,  8'd10,  8'd10,  7'd1,   4'd1,  3'd0, 3'd3}, 1'b1, 2'd3,
      '{{CMD_PAGE | 8'd1, 1'b0, 1'b0}, {CMD_PAGE | 8'd1, 1'b0, 1'b0},
        {CMD_PAGE | 8'd1, 1'b0, 1'b1}}},
    '{'{OP_ERASE, 8'd10,  8'd10,  7'd1,   4'd1,  3'd5, 3'd0}, 1'b1, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd200, 8'd250, 7'd1,   4'd1,  3'd1, 3'd1}, 1'b1, 2'd2,
      '{{CMD_PAGE | 8'h1f, 1'b0, 1'b0}, {CMD_COLUMN | 8'd200, 1'b0, 1'b1}, '0}},
    '{'{OP_DRAW,  8'd5,   8'd9,   7'd1,   4'd1,  3'd1, 3'd1}, 1'b1, 2'd3,
      '{{CMD_PAGE | 8'd1, 1'b0, 1'b0}, {CMD_COLUMN | 8'd5, 1'b0, 1'b0},
        {8'h02, 1'b1, 1'b1}}},
    '{'{OP_ERASE, 8'd5,   8'd9,   7'd1,   4'd1,  3'd1, 3'd1}, 1'b1, 2'd3,
      '{{CMD_PAGE | 8'd1, 1'b0, 1'b0}, {CMD_COLUMN | 8'd5, 1'b0, 1'b0},
        {8'h00, 1'b1, 1'b1}}},
    '{'{OP_DRAW,  8'd0,   8'd0,   7'd0,   4'd0,  3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd83,  8'd47,  7'd1,   4'd1,  3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd255, 8'd255, 7'd13,  4'd1,  3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd10,  8'd20,  7'd127, 4'd15, 3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd20,  8'd6,   7'd1,   4'd6,  3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd30,  8'd44,  7'd79,  4'd12, 3'd7, 3'd7}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd78,  8'd0,   7'd60,  4'd13, 3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd40,  8'd40,  7'd84,  4'd0,  3'd3, 3'd2}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_ERASE, 8'd0,   8'd0,   7'd0,   4'd0,  3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd0,   8'd0,   7'd0,   4'd8,  3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_ERASE, 8'd1,   8'd1,   7'd72,  4'd8,  3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd83,  8'd0,   7'd76,  4'd1,  3'd1, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd0,   8'd47,  7'd77,  4'd8,  3'd7, 3'd1}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd50,  8'd24,  7'd0,   4'd15, 3'd1, 3'd1}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_ERASE, 8'd255, 8'd0,   7'd76,  4'd8,  3'd2, 3'd4}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_DRAW,  8'd127, 8'd128, 7'd100, 4'd7,  3'd7, 3'd7}, 1'b0, 2'd0, NO_WORDS},
    '{'{OP_ERASE, 8'd84,  8'd48,  7'd1,   4'd1,  3'd1, 3'd1}, 1'b1, 2'd2,
      '{{CMD_PAGE | 8'd6, 1'b0, 1'b0}, {CMD_COLUMN | 8'd84, 1'b0, 1'b1}, '0}},
    '{'{OP_DRAW,  8'd60,  8'd32,  7'd64,  4'd0,  3'd7, 3'd4}, 1'b0, 2'd0, NO_WORDS}
  };

  logic clk;
  logic rst;

  pfsb_req_if blit();
  pfsb_out_if lcd();

  page_framebuffer_sprite_blit #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_PAGES  (SCREEN_PAGES)
  ) uut (
    .clk (clk),
    .rst (rst),
    .blit(blit),
    .lcd (lcd)
  );

  logic [7:0] frame_img [SCREEN_PAGES*SCREEN_COLUMNS];
  lcd_word_t  blit_words [$];
  lcd_word_t  lcd_pending [$];

  logic       cur_typed;
  logic [1:0] cur_n_typed;
  word_set_t  cur_words;

  bit gaps_on;
  bit stalls_on;
  int errors;
  int cycles;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int pick_gap(input bit on, input int longest);
    int p;
    if (!on) begin
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 60) begin
      return 0;
    end
    if (p < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, longest);
  endfunction

  function automatic bit sprite_pixel(input int col, input int row);
    logic [7:0] cell_bits;
    if (col >= ROM_COLUMNS || row >= ROM_ROWS) begin
      return 1'b0;
    end
    cell_bits = SPRITE_ROM[(row / 8) * ROM_COLUMNS + col];
    return cell_bits[row % 8];
  endfunction

  // expands one request into blit_words and updates frame_img
  function automatic void paint_sprite(input blit_req_t r);
    logic [2:0] w;
    logic [2:0] h;
    logic [7:0] sx;
    logic [7:0] sy;
    int idx;
    blit_words.delete();
    w = (r.width > MAX_WIDTH) ? MAX_WIDTH : r.width;
    h = (r.height > MAX_HEIGHT) ? MAX_HEIGHT : r.height;
    for (int row = 0; row < h; row++) begin
      sy = r.pos_y + 8'(row);
      blit_words.push_back('{CMD_PAGE | {3'b000, sy[7:3]}, 1'b0, 1'b0});
      for (int col = 0; col < w; col++) begin
        sx = r.pos_x + 8'(col);
        blit_words.push_back('{CMD_COLUMN | sx, 1'b0, 1'b0});
        if (sprite_pixel(r.map_x + col, r.map_y + row) &&
            sx < SCREEN_COLUMNS && sy < 8 * SCREEN_PAGES) begin
          idx = sy[7:3] * SCREEN_COLUMNS + sx;
          frame_img[idx][sy[2:0]] = (r.operation == OP_DRAW);
          blit_words.push_back('{frame_img[idx], 1'b1, 1'b0});
        end
      end
    end
    if (blit_words.size() > 0) begin
      blit_words[blit_words.size()-1].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    lcd_word_t want;
    if (!rst) begin
      if (blit.valid && blit.ready) begin
        paint_sprite('{blit.operation, blit.pos_x, blit.pos_y, blit.map_x, blit.map_y,
                       blit.width, blit.height});
        if (cur_typed) begin
          for (int k = 0; k < cur_n_typed; k++) begin
            lcd_pending.push_back(cur_words[k]);
          end
        end else begin
          foreach (blit_words[k]) begin
            lcd_pending.push_back(blit_words[k]);
          end
        end
      end
      if (lcd.valid && lcd.ready) begin
        if (lcd_pending.size() == 0) begin
          report($sformatf("unexpected word %02h is_data %0b last %0b",
                           lcd.out_byte, lcd.is_data, lcd.last));
        end else begin
          want = lcd_pending.pop_front();
          if (lcd.out_byte !== want.out_byte) begin
            report($sformatf("out_byte got %02h want %02h", lcd.out_byte, want.out_byte));
          end
          if (lcd.is_data !== want.is_data) begin
            report($sformatf("is_data got %0b want %0b (byte %02h)",
                             lcd.is_data, want.is_data, want.out_byte));
          end
          if (lcd.last !== want.last) begin
            report($sformatf("last got %0b want %0b (byte %02h)",
                             lcd.last, want.last, want.out_byte));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    int n;
    if (rst) begin
      lcd.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      lcd.ready <= 1'b0;
      stall_left--;
    end else begin
      n = pick_gap(stalls_on, 20);
      if (n > 0) begin
        lcd.ready <= 1'b0;
        stall_left = n - 1;
      end else begin
        lcd.ready <= 1'b1;
      end
    end
  end

  task automatic send_blit(input blit_req_t r, input logic typed, input logic [1:0] n,
                           input word_set_t words);
    int gap;
    gap = pick_gap(gaps_on, 40);
    if (gap > 0) begin
      blit.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    blit.valid     <= 1'b1;
    blit.operation <= r.operation;
    blit.pos_x     <= r.pos_x;
    blit.pos_y     <= r.pos_y;
    blit.map_x     <= r.map_x;
    blit.map_y     <= r.map_y;
    blit.width     <= r.width;
    blit.height    <= r.height;
    cur_typed      <= typed;
    cur_n_typed    <= n;
    cur_words      <= words;
    @(posedge clk);
    while (!blit.ready) @(posedge clk);
  endtask

  task automatic drain_lcd();
    blit.valid <= 1'b0;
    @(posedge clk);
    while (lcd_pending.size() != 0) @(posedge clk);
  endtask

  function automatic blit_req_t random_sprite();
    blit_req_t r;
    r.operation = OP_DRAW;
    r.pos_x     = 8'($urandom_range(0, SCREEN_COLUMNS - 1));
    r.pos_y     = 8'($urandom_range(0, 8 * SCREEN_PAGES - 1));
    r.map_x     = 7'($urandom_range(0, ROM_COLUMNS - 7));
    r.map_y     = 4'($urandom_range(0, ROM_ROWS - 4));
    r.width     = 3'($urandom_range(1, MAX_WIDTH));
    r.height    = 3'($urandom_range(1, MAX_HEIGHT));
    return r;
  endfunction

  function automatic blit_req_t random_request();
    blit_req_t r;
    if ($urandom_range(0, 99) < 70) begin
      r = random_sprite();
      r.operation = 1'($urandom_range(0, 1));
    end else begin
      r.operation = 1'($urandom_range(0, 1));
      r.pos_x     = 8'($urandom_range(0, 255));
      r.pos_y     = 8'($urandom_range(0, 255));
      r.map_x     = 7'($urandom_range(0, 127));
      r.map_y     = 4'($urandom_range(0, 15));
      r.width     = 3'($urandom_range(0, 7));
      r.height    = 3'($urandom_range(0, 7));
    end
    return r;
  endfunction

  initial begin
    blit_req_t r;
    blit_req_t sprite;
    int sent;
    bit paused;
    rst            = 1'b1;
    blit.valid     = 1'b0;
    blit.operation = OP_ERASE;
    blit.pos_x     = '0;
    blit.pos_y     = '0;
    blit.map_x     = '0;
    blit.map_y     = '0;
    blit.width     = '0;
    blit.height    = '0;
    cur_typed      = 1'b0;
    cur_n_typed    = '0;
    cur_words      = NO_WORDS;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    foreach (frame_img[k]) frame_img[k] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_blit(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].n_typed,
                DIRECTED[k].words);
    end

    // random part: sprite moves as erase-then-draw pairs, plus stray requests
    sprite = random_sprite();
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on   = !(sent >= 80 && sent < 120);
      stalls_on = gaps_on;
      if (!paused && sent >= 150) begin
        paused = 1'b1;
        drain_lcd();
      end
      if ($urandom_range(0, 99) < 55) begin
        r = sprite;
        r.operation = OP_ERASE;
        send_blit(r, 1'b0, 2'd0, NO_WORDS);
        sprite.pos_x = sprite.pos_x + 8'($urandom_range(0, 6)) - 8'd3;
        sprite.pos_y = sprite.pos_y + 8'($urandom_range(0, 6)) - 8'd3;
        sprite.operation = OP_DRAW;
        send_blit(sprite, 1'b0, 2'd0, NO_WORDS);
        sent += 2;
        if ($urandom_range(0, 9) == 0) begin
          sprite = random_sprite();
        end
      end else begin
        send_blit(random_request(), 1'b0, 2'd0, NO_WORDS);
        sent++;
      end
    end

    drain_lcd();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lcd_pending.size() != 0) begin
      report($sformatf("%0d words never arrived", lcd_pending.size()));
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pfsb_pkg.sv
rtl/pfsb_req_if.sv
rtl/pfsb_out_if.sv
rtl/pfsb_ram.sv
rtl/page_framebuffer_sprite_blit.sv
tb/testbench.sv
